### design/deterministic_window_admission_macros.svh
// ----------------------------------------------------------------------------
// deterministic_window_admission_macros.svh
// Assertion macros for the window admission gate.
// ----------------------------------------------------------------------------
`ifndef DETERMINISTIC_WINDOW_ADMISSION_MACROS_SVH
`define DETERMINISTIC_WINDOW_ADMISSION_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, held off while in reset
`define DWA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define DWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DWA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### design/dwa_pkg.sv
// ----------------------------------------------------------------------------
// dwa_pkg
// Shared types and constants of the window admission gate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwa_pkg;

    localparam int TIME_W = 64;
    localparam int MS_W   = 16;
    localparam int PCT_W  = 7;
    localparam int CYC_W  = 36;                 // 65535 * 1e6 < 2^36
    localparam int PROD_W = CYC_W + PCT_W;      // phase bounds, up to 127% of a cycle
    localparam int MP_W   = MS_W + PCT_W;       // millis * percent
    localparam int CNT_W  = 32;
    localparam int STEP_W = $clog2(TIME_W);

    localparam logic [19:0]      NS_PER_MS  = 20'd1000000;
    localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
    // ns in one percent of a 1 ms cycle; bounds are exact multiples of it
    localparam logic [13:0]      NS_PER_PCT = 14'd10000;

    // operation codes
    localparam logic [2:0] OP_ADMIT_HOST = 3'd0;
    localparam logic [2:0] OP_ADMIT_GC   = 3'd1;
    localparam logic [2:0] OP_PROBE      = 3'd2;
    localparam logic [2:0] OP_READ       = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    // phase codes
    localparam logic [1:0] PH_HOST   = 2'd0;
    localparam logic [1:0] PH_SHARED = 2'd1;
    localparam logic [1:0] PH_GC     = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_HOST   = 3'd1;
    localparam logic [2:0] REG_SHARED = 3'd2;
    localparam logic [2:0] REG_MILLIS = 3'd3;
    localparam logic [2:0] REG_ORIGIN = 3'd4;

    // counter store layout
    localparam int         CNT_DEPTH     = 13;
    localparam int         CNT_AW        = $clog2(CNT_DEPTH);
    localparam logic [3:0] IDX_HOST_OK   = 4'd0;
    localparam logic [3:0] IDX_HOST_REJ  = 4'd3;
    localparam logic [3:0] IDX_GC_OK     = 4'd6;
    localparam logic [3:0] IDX_GC_REJ    = 4'd9;
    localparam logic [3:0] IDX_TRANS     = 4'd12;
    localparam logic [3:0] IDX_LAST      = 4'd13;

    // stream widths
    localparam int IN_W   = 72;
    localparam int USER_W = 3;
    localparam int OUT_W  = 40;

    typedef struct packed {
        logic              enabled;
        logic [PCT_W-1:0]  host_share;
        logic [PCT_W-1:0]  shared_pct;
        logic [MS_W-1:0]   millis;
        logic [TIME_W-1:0] origin;
    } cfg_t;

    typedef struct packed {
        logic       done;
        logic [1:0] phase;
    } phase_res_t;

endpackage

### design/dwa_ram.sv
// ----------------------------------------------------------------------------
// dwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/dwa_phase_unit.sv
// ----------------------------------------------------------------------------
// dwa_phase_unit
// Cycle position and phase: short multiplies give the cycle length and the
// phase bounds (millis * percent * 10000 ns), then a bit-serial remainder
// by the cycle length gives the position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwa_phase_unit
    import dwa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] now_ns,
    input  cfg_t              cfg,
    output phase_res_t        res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_CMP
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [TIME_W-1:0]   dvd_reg;      // now - origin, shifted out msb first
    logic [CYC_W-1:0]    cyc_reg;
    logic [CYC_W-1:0]    rem_reg;      // becomes the position in the cycle
    logic [PROD_W-1:0]   hq_reg;       // millis * host percent, then host_end
    logic [PROD_W-1:0]   sq_reg;       // millis * shared percent, then shared length
    logic                done_reg;
    logic [1:0]          phase_reg;

    logic [CYC_W:0]      trial;
    logic                trial_ge;
    logic [CYC_W-1:0]    rem_next;
    logic [PROD_W:0]     shared_end;
    logic [1:0]          phase_next;

    // one remainder step per cycle
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[TIME_W-1]};
        trial_ge  = trial >= {1'b0, cyc_reg};
        rem_next  = trial_ge ? CYC_W'(trial - {1'b0, cyc_reg}) : trial[CYC_W-1:0];
    end

    // phase from position and bounds
    always_comb
    begin
        shared_end = {1'b0, hq_reg} + {1'b0, sq_reg};
        if (cfg.millis == '0)
        begin
            phase_next = PH_HOST;
        end
        else if ({{(PROD_W-CYC_W){1'b0}}, rem_reg} < hq_reg)
        begin
            phase_next = PH_HOST;
        end
        else if ({{(PROD_W-CYC_W+1){1'b0}}, rem_reg} < shared_end)
        begin
            phase_next = PH_SHARED;
        end
        else
        begin
            phase_next = PH_GC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            phase_reg <= PH_HOST;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        dvd_reg   <= now_ns - cfg.origin;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    cyc_reg   <= CYC_W'(cfg.millis) * CYC_W'(NS_PER_MS);
                    hq_reg    <= PROD_W'(cfg.millis) * PROD_W'(cfg.host_share);
                    sq_reg    <= PROD_W'(cfg.millis) * PROD_W'(cfg.shared_pct);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    // cycle * pct / 100 is exact: millis * pct * 10000
                    hq_reg    <= PROD_W'(hq_reg[MP_W-1:0]) * PROD_W'(NS_PER_PCT);
                    sq_reg    <= PROD_W'(sq_reg[MP_W-1:0]) * PROD_W'(NS_PER_PCT);
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= rem_next;
                    dvd_reg  <= {dvd_reg[TIME_W-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(TIME_W - 1))
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    phase_reg <= phase_next;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.done  = done_reg;
    assign res.phase = phase_reg;

endmodule

### design/deterministic_window_admission.sv
// ----------------------------------------------------------------------------
// deterministic_window_admission
// Time-sliced admission gate: host I/O versus garbage collection.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | payload
//  ---------+--------------------------------+-----------------------------------
//  input    | s_tvalid s_tready s_tdata/user | now_ns, counter_index; operation
//  output   | m_tvalid m_tready m_tdata      | phase, host_ok, gc_ok, counter_value
//  config   | cfg_valid cfg_ready            | cfg_index, cfg_data (always ready)
//
//  Admit or probe with windows enabled runs the phase unit, with its 64-step
//  serial remainder of (now - origin) by the cycle length. Counter updates
//  then read and write the single counter RAM, once more for a phase change.
//  Disabled, read, clear and unknown operations bypass the phase unit.
//  One item is in work at a time; the output register lets the next item in
//  while a result waits. Reset clears the counters at once via valid bits.
//
`timescale 1ns / 1ps
`include "deterministic_window_admission_macros.svh"

module deterministic_window_admission
    import dwa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input items
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,    // [63:0] now_ns, [67:64] counter_index
    input  logic [USER_W-1:0] s_tuser,    // [2:0] operation
    // result items
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,    // [1:0] phase, [2] host_ok, [3] gc_ok,
                                          // [35:4] counter_value
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [TIME_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_TR_RD,
        ST_TR_WR,
        ST_VAL_RD,
        ST_VAL_TAKE,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    cfg_t                   cfg_reg;
    logic [2:0]             op_reg;
    logic [CNT_AW-1:0]      raddr_reg;
    logic [CNT_DEPTH-1:0]   cnt_valid_reg;   // cleared entries read as zero
    logic [1:0]             prev_phase_reg;
    logic                   trans_reg;
    logic [1:0]             res_phase_reg;
    logic                   res_hok_reg;
    logic                   res_gok_reg;
    logic [CNT_W-1:0]       res_val_reg;
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;

    logic                   s_accept;
    logic [2:0]             in_op;
    logic [3:0]             in_idx;
    logic                   ph_start;
    phase_res_t             ph_res;
    logic                   ph_hok;
    logic                   ph_gok;
    logic                   ph_ok;
    logic [3:0]             ph_base;
    logic                   ram_we;
    logic [CNT_W-1:0]       ram_rdata;
    logic [CNT_W-1:0]       cnt_eff;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign in_op     = s_tuser;
    assign in_idx    = s_tdata[67:64];

    // phase unit runs only for admit and probe with windows on
    assign ph_start = s_accept && cfg_reg.enabled &&
                      (in_op inside {OP_ADMIT_HOST, OP_ADMIT_GC, OP_PROBE});

    dwa_phase_unit u_phase (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ph_start),
        .now_ns (s_tdata[TIME_W-1:0]),
        .cfg    (cfg_reg),
        .res    (ph_res)
    );

    // decision and counter slot for the phase just computed
    always_comb
    begin
        ph_hok = (ph_res.phase != PH_GC);
        ph_gok = (ph_res.phase != PH_HOST);
        ph_ok  = (op_reg == OP_ADMIT_HOST) ? ph_hok : ph_gok;
        if (op_reg == OP_ADMIT_HOST)
        begin
            ph_base = ph_ok ? IDX_HOST_OK : IDX_HOST_REJ;
        end
        else
        begin
            ph_base = ph_ok ? IDX_GC_OK : IDX_GC_REJ;
        end
    end

    // counter RAM: 12 phase counters and the transition count
    assign ram_we  = (state_reg == ST_CNT_WR) || (state_reg == ST_TR_WR);
    assign cnt_eff = cnt_valid_reg[raddr_reg] ? ram_rdata : '0;

    dwa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (raddr_reg),
        .wdata (cnt_eff + 1'b1),
        .raddr (raddr_reg),
        .rdata (ram_rdata)
    );

    // configuration registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled    <= 1'b0;
            cfg_reg.host_share <= PCT_FULL;
            cfg_reg.shared_pct <= '0;
            cfg_reg.millis     <= MS_W'(1);
            cfg_reg.origin     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE: cfg_reg.enabled    <= cfg_data[0];
                REG_HOST:   cfg_reg.host_share <= cfg_data[PCT_W-1:0];
                REG_SHARED: cfg_reg.shared_pct <= cfg_data[PCT_W-1:0];
                REG_MILLIS: cfg_reg.millis     <= cfg_data[MS_W-1:0];
                REG_ORIGIN: cfg_reg.origin     <= cfg_data;
                default:    ;
            endcase
        end
    end

    // item sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_valid_reg  <= '0;
            prev_phase_reg <= PH_HOST;
            trans_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            op_reg         <= OP_ADMIT_HOST;
            raddr_reg      <= '0;
        end
        else
        begin
            // ST_DONE handles the output register itself
            if (m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        op_reg        <= in_op;
                        res_phase_reg <= PH_HOST;
                        res_hok_reg   <= 1'b0;
                        res_gok_reg   <= 1'b0;
                        res_val_reg   <= '0;
                        state_reg     <= ST_DONE;
                        case (in_op)
                            OP_ADMIT_HOST, OP_ADMIT_GC, OP_PROBE:
                            begin
                                if (cfg_reg.enabled)
                                begin
                                    state_reg <= ST_CALC;
                                end
                                else
                                begin
                                    res_hok_reg <= 1'b1;
                                    res_gok_reg <= 1'b1;
                                end
                            end
                            OP_READ:
                            begin
                                if (in_idx <= IDX_TRANS)
                                begin
                                    raddr_reg <= CNT_AW'(in_idx);
                                    state_reg <= ST_VAL_RD;
                                end
                                else if (in_idx == IDX_LAST)
                                begin
                                    res_val_reg <= CNT_W'(prev_phase_reg);
                                end
                            end
                            OP_CLEAR:
                            begin
                                cnt_valid_reg  <= '0;
                                prev_phase_reg <= PH_HOST;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CALC:
                begin
                    if (ph_res.done)
                    begin
                        res_phase_reg <= ph_res.phase;
                        res_hok_reg   <= ph_hok;
                        res_gok_reg   <= ph_gok;
                        if (op_reg == OP_PROBE)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            raddr_reg      <= CNT_AW'(ph_base + {2'b00, ph_res.phase});
                            trans_reg      <= (prev_phase_reg != ph_res.phase);
                            prev_phase_reg <= ph_res.phase;
                            state_reg      <= ST_CNT_RD;
                        end
                    end
                end
                ST_CNT_RD:
                begin
                    state_reg <= ST_CNT_WR;
                end
                ST_CNT_WR:
                begin
                    cnt_valid_reg[raddr_reg] <= 1'b1;
                    if (trans_reg)
                    begin
                        raddr_reg <= CNT_AW'(IDX_TRANS);
                        state_reg <= ST_TR_RD;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_TR_RD:
                begin
                    state_reg <= ST_TR_WR;
                end
                ST_TR_WR:
                begin
                    cnt_valid_reg[raddr_reg] <= 1'b1;
                    state_reg                <= ST_DONE;
                end
                ST_VAL_RD:
                begin
                    state_reg <= ST_VAL_TAKE;
                end
                ST_VAL_TAKE:
                begin
                    res_val_reg <= cnt_eff;
                    state_reg   <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'b0000, res_val_reg, res_gok_reg, res_hok_reg,
                                         res_phase_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `DWA_ASSERT_IMPL(a_done_in_calc, clk, rst_n, ph_res.done, state_reg == ST_CALC,
                     "phase result outside calc state")
    `DWA_ASSERT_IMPL(a_phase_code, clk, rst_n, m_tvalid, m_tdata[1:0] != 2'd3,
                     "result phase out of range")
    `DWA_ASSERT_NEXT(a_clear_wipes, clk, rst_n, s_accept && (in_op == OP_CLEAR),
                     (cnt_valid_reg == '0) && (prev_phase_reg == PH_HOST),
                     "clear did not reset the counters")
    `DWA_ASSERT_IMPL(a_trans_slot, clk, rst_n, state_reg == ST_TR_WR,
                     raddr_reg == CNT_AW'(IDX_TRANS),
                     "transition update at wrong counter")

endmodule

### dv/dwa_window_checker.sv
// ----------------------------------------------------------------------------
// dwa_window_checker
// Watches the config, input and result channels of the window admission
// gate, keeps its own copy of the gate settings and counters, and matches
// every result item against the oldest predicted decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwa_window_checker
    import dwa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [USER_W-1:0] s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [TIME_W-1:0] cfg_data,
    output int                mismatches,
    output int                outstanding,
    output int                results_seen
);

    localparam int ADMIT_SLOTS = IDX_TRANS;

    typedef struct packed {
        logic [1:0]       phase;
        logic             host_ok;
        logic             gc_ok;
        logic [CNT_W-1:0] value;
    } gate_res_t;

    // gate settings as last written
    logic              win_en;
    logic [PCT_W-1:0]  host_share;
    logic [PCT_W-1:0]  shared_pct;
    logic [MS_W-1:0]   millis;
    logic [TIME_W-1:0] origin;

    // admit counters, transitions, last phase seen by an admit
    logic [CNT_W-1:0] admit_counts [ADMIT_SLOTS];
    logic [CNT_W-1:0] trans_count;
    logic [1:0]       prev_phase;

    gate_res_t pending_decisions [$];

    initial begin
        mismatches   = 0;
        results_seen = 0;
    end

    function automatic logic [1:0] window_phase(input logic [TIME_W-1:0] now_ns);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] offset;
        logic [TIME_W-1:0] host_end;
        logic [TIME_W-1:0] shared_end;
        span = 64'(millis) * 64'(NS_PER_MS);
        if (span == 0)
            return PH_HOST;
        offset     = (now_ns - origin) % span;
        host_end   = span * 64'(host_share) / 64'(PCT_FULL);
        shared_end = host_end + span * 64'(shared_pct) / 64'(PCT_FULL);
        if (offset < host_end)
            return PH_HOST;
        if (offset < shared_end)
            return PH_SHARED;
        return PH_GC;
    endfunction

    // Works out the gate's answer for one item and advances the counters.
    function automatic gate_res_t gate_decision(input logic [2:0] op,
                                                input logic [TIME_W-1:0] now_ns,
                                                input logic [3:0] idx);
        gate_res_t  res;
        logic [1:0] ph;
        logic       allowed;
        logic [3:0] slot;
        res = '0;
        if (op == OP_ADMIT_HOST || op == OP_ADMIT_GC || op == OP_PROBE) begin
            if (!win_en) begin
                res.phase   = PH_HOST;
                res.host_ok = 1'b1;
                res.gc_ok   = 1'b1;
            end
            else begin
                ph          = window_phase(now_ns);
                res.phase   = ph;
                res.host_ok = (ph == PH_HOST) || (ph == PH_SHARED);
                res.gc_ok   = (ph == PH_SHARED) || (ph == PH_GC);
                if (op != OP_PROBE) begin
                    if (op == OP_ADMIT_HOST) begin
                        allowed = res.host_ok;
                        slot    = allowed ? IDX_HOST_OK : IDX_HOST_REJ;
                    end
                    else begin
                        allowed = res.gc_ok;
                        slot    = allowed ? IDX_GC_OK : IDX_GC_REJ;
                    end
                    if (prev_phase != ph) begin
                        trans_count = trans_count + 1'b1;
                        prev_phase  = ph;
                    end
                    admit_counts[slot + ph] = admit_counts[slot + ph] + 1'b1;
                end
            end
        end
        else if (op == OP_READ) begin
            if (idx < IDX_TRANS)
                res.value = admit_counts[idx];
            else if (idx == IDX_TRANS)
                res.value = trans_count;
            else if (idx == IDX_LAST)
                res.value = CNT_W'(prev_phase);
        end
        else if (op == OP_CLEAR) begin
            foreach (admit_counts[i])
                admit_counts[i] = '0;
            trans_count = '0;
            prev_phase  = PH_HOST;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        gate_res_t want;
        gate_res_t got;
        if (!rst_n) begin
            win_en     = 1'b0;
            host_share = PCT_FULL;
            shared_pct = '0;
            millis     = MS_W'(1);
            origin     = '0;
            foreach (admit_counts[i])
                admit_counts[i] = '0;
            trans_count = '0;
            prev_phase  = PH_HOST;
            pending_decisions.delete();
            outstanding <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENABLE: win_en     = cfg_data[0];
                    REG_HOST:   host_share = cfg_data[PCT_W-1:0];
                    REG_SHARED: shared_pct = cfg_data[PCT_W-1:0];
                    REG_MILLIS: millis     = cfg_data[MS_W-1:0];
                    REG_ORIGIN: origin     = cfg_data;
                    default: ;
                endcase
            end
            // results first, so a spurious one cannot pair with a fresh item
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.phase   = m_tdata[1:0];
                got.host_ok = m_tdata[2];
                got.gc_ok   = m_tdata[3];
                got.value   = m_tdata[35:4];
                if (pending_decisions.size() == 0) begin
                    $error("result item with no decision pending");
                    mismatches++;
                end
                else begin
                    want = pending_decisions.pop_front();
                    if (got.phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, got.phase);
                        mismatches++;
                    end
                    if (got.host_ok !== want.host_ok) begin
                        $error("host_ok: expected %0d, got %0d", want.host_ok, got.host_ok);
                        mismatches++;
                    end
                    if (got.gc_ok !== want.gc_ok) begin
                        $error("gc_ok: expected %0d, got %0d", want.gc_ok, got.gc_ok);
                        mismatches++;
                    end
                    if (got.value !== want.value) begin
                        $error("counter_value: expected %0d, got %0d", want.value, got.value);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_decisions.push_back(gate_decision(s_tuser[2:0],
                                                          s_tdata[TIME_W-1:0],
                                                          s_tdata[TIME_W+3:TIME_W]));
            outstanding <= pending_decisions.size();
        end
    end

endmodule

### dv/deterministic_window_admission_tb.sv
// ----------------------------------------------------------------------------
// deterministic_window_admission_tb
// Drives admit, probe, read, clear and unknown operations into the window
// admission gate under a series of window settings and flow-control modes;
// the checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deterministic_window_admission_tb;
    import dwa_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;  // watchdog limit on the whole run
    localparam int MAX_GAP       = 20;      // longest sender gap between items
    localparam int LONG_STALL    = 600;     // receiver hold-off, several items long
    localparam int SETTLE_CYCLES = 80;      // settle time before the final report
    localparam int PER_SETTING   = 42;      // random items per window setting
    localparam int SETTINGS_PER  = 6;       // window settings per flow-control mode

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;     // [63:0] now_ns, [67:64] counter_index
    logic [USER_W-1:0] s_tuser;     // [2:0] operation
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;     // [1:0] phase, [2] host_ok, [3] gc_ok,
                                    // [35:4] counter_value
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [TIME_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int results_seen;

    // flow-control knobs, percent of cycles spent idle
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic stall_go = 1'b0;

    int cycle_count = 0;
    int items_sent = 0;
    int settings_applied = 0;

    // window settings currently in the block, used to aim timestamps at edges
    logic [PCT_W-1:0]  cur_hp;
    logic [PCT_W-1:0]  cur_sp;
    logic [MS_W-1:0]   cur_ms;
    logic [TIME_W-1:0] cur_origin;

    deterministic_window_admission uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dwa_window_checker window_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Hard stop if the run hangs.
    initial begin : watchdog
        while (cycle_count <= CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL deterministic_window_admission");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off so the
    // output register and the work slot fill and s_tready drops.
    initial begin : receiver
        logic stall_done;
        stall_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_go && !stall_done) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one item after a random gap; valid stays up after the handshake
    // so back-to-back items never drop it within a step.
    task automatic send_item(input logic [2:0] op, input logic [TIME_W-1:0] now_ns,
                             input logic [3:0] idx);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_W-TIME_W-4){1'b0}}, idx, now_ns};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Writes all five registers back to back, led by a write to an unused
    // index that the block must ignore.
    task automatic apply_settings(input logic en, input logic [PCT_W-1:0] hp,
                                  input logic [PCT_W-1:0] sp, input logic [MS_W-1:0] ms,
                                  input logic [TIME_W-1:0] org);
        logic [2:0]        idxs [6];
        logic [TIME_W-1:0] vals [6];
        idxs[0] = REG_ORIGIN + 3'd1 + 3'($urandom_range(2));
        vals[0] = {$urandom, $urandom};
        idxs[1] = REG_ENABLE;   vals[1] = 64'(en);
        idxs[2] = REG_HOST;     vals[2] = 64'(hp);
        idxs[3] = REG_SHARED;   vals[3] = 64'(sp);
        idxs[4] = REG_MILLIS;   vals[4] = 64'(ms);
        idxs[5] = REG_ORIGIN;   vals[5] = org;
        cfg_valid <= 1'b1;
        for (int i = 0; i < 6; i++) begin
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_hp     = hp;
        cur_sp     = sp;
        cur_ms     = ms;
        cur_origin = org;
        settings_applied++;
    endtask

    // Timestamp aimed at a phase edge, inside a random cycle, or anywhere.
    function automatic logic [TIME_W-1:0] pick_now();
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] host_end;
        logic [TIME_W-1:0] shared_end;
        logic [TIME_W-1:0] pos;
        span = 64'(cur_ms) * 64'(NS_PER_MS);
        if (span == 0 || $urandom_range(9) == 0)
            return {$urandom, $urandom};
        host_end   = span * 64'(cur_hp) / 64'(PCT_FULL);
        shared_end = host_end + span * 64'(cur_sp) / 64'(PCT_FULL);
        case ($urandom_range(7))
            0:       pos = host_end;
            1:       pos = host_end - 1;
            2:       pos = shared_end;
            3:       pos = shared_end - 1;
            4:       pos = span - 1;
            default: pos = {$urandom, $urandom} % span;
        endcase
        return cur_origin + span * 64'($urandom) + pos;
    endfunction

    task automatic send_random_item();
        int         r;
        logic [2:0] op;
        r = $urandom_range(99);
        if (r < 36)
            op = OP_ADMIT_HOST;
        else if (r < 72)
            op = OP_ADMIT_GC;
        else if (r < 82)
            op = OP_PROBE;
        else if (r < 93)
            op = OP_READ;
        else if (r < 96)
            op = OP_CLEAR;
        else
            op = OP_CLEAR + 3'($urandom_range(1, 3));   // undefined codes
        send_item(op, pick_now(), 4'($urandom_range(15)));
    endtask

    initial begin : stimulus
        int               k;
        logic             en;
        logic [PCT_W-1:0] hp;
        logic [PCT_W-1:0] sp;
        logic [MS_W-1:0]  ms;
        logic [TIME_W-1:0] org;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cur_hp     = PCT_FULL;
        cur_sp     = '0;
        cur_ms     = MS_W'(1);
        cur_origin = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: windows off, everything allowed, nothing counted.
        send_item(OP_ADMIT_HOST, '0, IDX_HOST_OK);
        send_item(OP_ADMIT_GC, '1, 4'hF);
        send_item(OP_PROBE, 64'h8000_0000_0000_0000, IDX_GC_OK);
        send_item(OP_READ, '0, IDX_HOST_OK);
        send_item(OP_READ, '0, IDX_TRANS);
        send_item(OP_CLEAR + 3'd3, '1, 4'hF);
        send_item(OP_CLEAR + 3'd1, '0, IDX_LAST);
        drain_results();

        // 1 ms cycle: host-only below 400 us, shared below 700 us, then gc-only.
        // Walk each edge, both admit kinds, a rejection in each direction.
        apply_settings(1'b1, PCT_W'(40), PCT_W'(30), MS_W'(1), '0);
        send_item(OP_ADMIT_HOST, 64'd0, IDX_HOST_OK);
        send_item(OP_ADMIT_HOST, 64'd399999, IDX_HOST_OK);
        send_item(OP_ADMIT_HOST, 64'd400000, IDX_HOST_OK);
        send_item(OP_ADMIT_GC, 64'd699999, IDX_GC_OK);
        send_item(OP_ADMIT_GC, 64'd700000, IDX_GC_OK);
        send_item(OP_ADMIT_HOST, 64'd999999, IDX_HOST_OK);
        send_item(OP_ADMIT_GC, 64'd1000000, IDX_GC_OK);
        send_item(OP_PROBE, '1, IDX_TRANS);
        send_item(OP_READ, '0, IDX_HOST_REJ + 4'd2);
        send_item(OP_READ, '0, IDX_GC_REJ);
        send_item(OP_READ, '0, IDX_TRANS);
        send_item(OP_READ, '0, IDX_LAST);
        send_item(OP_READ, '1, IDX_LAST + 4'd1);
        send_item(OP_CLEAR, '0, IDX_HOST_OK);
        send_item(OP_READ, '0, IDX_TRANS);
        send_item(OP_READ, '0, IDX_GC_OK + 4'd1);
        drain_results();

        // Random part: three flow-control modes, several window settings each.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct <= 26; recv_idle_pct <= 53; end
                1: begin send_idle_pct <= 53; recv_idle_pct <= 26; end
                default: begin send_idle_pct <= 0; recv_idle_pct <= 0; end
            endcase
            for (int s = 0; s < SETTINGS_PER; s++) begin
                k   = mode * SETTINGS_PER + s;
                en  = ($urandom_range(7) != 0);
                hp  = PCT_W'($urandom_range(100));
                sp  = PCT_W'($urandom_range(100 - hp));
                org = {$urandom, $urandom};
                case ($urandom_range(3))
                    0, 1:    ms = MS_W'($urandom_range(1, 3));
                    2:       ms = MS_W'($urandom_range(1, 1000));
                    default: ms = MS_W'($urandom_range(65535));
                endcase
                if ($urandom_range(5) == 0) begin
                    // percentages past 100, bounds taken as they come
                    hp = PCT_W'($urandom_range(127));
                    sp = PCT_W'($urandom_range(127));
                end
                case (k)
                    0: begin    // largest everything
                        en = 1'b1; hp = '1; sp = '1; ms = '1; org = '1;
                    end
                    1: begin    // zero cycle length: host-only, still counted
                        en = 1'b1; hp = '0; sp = '0; ms = '0;
                    end
                    2: en = 1'b0;
                    6: begin    // whole cycle gc-only
                        en = 1'b1; hp = '0; sp = '0; ms = MS_W'(1); org = '0;
                    end
                    12: begin   // whole cycle host-only
                        en = 1'b1; hp = PCT_FULL; sp = '0; ms = MS_W'(1); org = '0;
                    end
                    default: ;
                endcase
                apply_settings(en, hp, sp, ms, org);
                // once, with the sender running flat out, hold the result side off
                if (mode == 2 && s == 0)
                    stall_go <= 1'b1;
                repeat (PER_SETTING) send_random_item();
                drain_results();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Window gate run: %0d items under %0d settings, %0d results checked.",
                 items_sent, settings_applied, results_seen);
        $display("Covered disabled, zero-length, oversized-percent and full-range cycles");
        if (mismatches == 0 && outstanding == 0)
            $display("PASS deterministic_window_admission");
        else
            $display("FAIL deterministic_window_admission");
        $finish;
    end

endmodule

### deterministic_window_admission.f
+incdir+design
design/dwa_pkg.sv
design/dwa_ram.sv
design/dwa_phase_unit.sv
design/deterministic_window_admission.sv
dv/dwa_window_checker.sv
dv/deterministic_window_admission_tb.sv
